// File: rtl/offt_pkg.sv
// Shared types and constants for the OBJ face fan triangulator.
// Holds widths, character codes, parser states and the front-to-back bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package offt_pkg;

  localparam int unsigned IDX_W       = 25;
  localparam int unsigned ACC_W       = IDX_W - 1;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned TRI_W       = 9 * IDX_W;
  localparam int unsigned OUT_DATA_W  = ((TRI_W + OFF_W + 7) / 8) * 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [1:0] {
    KIND_TRI = 2'd0,
    KIND_OBJ = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    M_START,
    M_SKIP,
    M_FKEY,
    M_OKEY,
    M_GAP,
    M_NUM_START,
    M_NUM_DIGITS
  } mode_e;

  // One corner, position in the low bits.
  typedef struct packed {
    logic [IDX_W-1:0] nrm;
    logic [IDX_W-1:0] tex;
    logic [IDX_W-1:0] pos;
  } corner_t;

  // One triangle, corner a in the low bits.
  typedef struct packed {
    corner_t c;
    corner_t b;
    corner_t a;
  } tri_t;

  // Everything one text byte causes: an optional triangle or object start,
  // then an optional end of text.
  typedef struct packed {
    logic             has_first;
    logic             first_obj;
    logic             has_end;
    tri_t             tri_data;
    logic [OFF_W-1:0] first_off;
    logic [OFF_W-1:0] end_off;
  } bundle_t;

endpackage

`default_nettype wire

// File: rtl/offt_front.sv
// Front end: classifies each text byte, parses corner groups and fans them
// into triangles. Pushes one result bundle per byte that causes output.
// Depends on offt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module offt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic               eot_i,
  output logic               push_o,
  output offt_pkg::bundle_t  bundle_o
);
  import offt_pkg::*;

  mode_e              mode_q, mode_d, mode_pre, num_mode;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               neg_q, neg_d;
  logic [1:0]         slot_q, slot_d, slot_eff;
  logic [1:0]         cnt_q, cnt_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [IDX_W-1:0]   cur_q [3];
  logic [IDX_W-1:0]   cur_d [3];
  corner_t            first_q, first_d, prev_q, prev_d;

  logic is_blank, is_cr, is_lf, is_digit, is_slash, is_minus;
  logic num_byte, start_corner, face_start, obj_emit, fin, tri_emit;
  logic [ACC_W+3:0] prod;
  tri_t             tri_out;
  logic [OFF_W-1:0] end_off;

  function automatic logic [IDX_W-1:0] field_value(logic [ACC_W-1:0] mag, logic neg);
    logic [IDX_W-1:0] ext;
    ext = {1'b0, mag};
    return neg ? ~ext : ext - IDX_W'(1);
  endfunction

  assign is_blank = (byte_i == CH_SP) || (byte_i == CH_TAB);
  assign is_cr    = (byte_i == CH_CR);
  assign is_lf    = (byte_i == CH_LF);
  assign is_digit = byte_i inside {[CH_0:CH_9]};
  assign is_slash = (byte_i == CH_SLASH);
  assign is_minus = (byte_i == CH_MINUS);

  assign slot_eff = start_corner ? 2'd0 : slot_q;

  // Next line mode and byte classification.
  always_comb begin
    num_byte     = 1'b0;
    start_corner = 1'b0;
    face_start   = 1'b0;
    obj_emit     = 1'b0;
    mode_pre     = mode_q;
    case (mode_q)
      M_START: begin
        if (byte_i == CH_F) mode_pre = M_FKEY;
        else if (byte_i == CH_O || byte_i == CH_G) mode_pre = M_OKEY;
        else if (!is_lf) mode_pre = M_SKIP;
      end
      M_FKEY: begin
        if (is_blank) begin
          mode_pre   = M_GAP;
          face_start = 1'b1;
        end else mode_pre = is_lf ? M_START : M_SKIP;
      end
      M_OKEY: begin
        if (is_blank) begin
          obj_emit = 1'b1;
          mode_pre = M_SKIP;
        end else mode_pre = is_lf ? M_START : M_SKIP;
      end
      M_GAP: begin
        if (is_lf) mode_pre = M_START;
        else if (!is_blank && !is_cr) begin
          start_corner = 1'b1;
          num_byte     = 1'b1;
        end
      end
      M_NUM_START, M_NUM_DIGITS: num_byte = 1'b1;
      default: mode_pre = is_lf ? M_START : M_SKIP;
    endcase

    num_mode = start_corner ? M_NUM_START : mode_q;
    if (num_byte) begin
      mode_pre = num_mode;
      if (is_digit) mode_pre = M_NUM_DIGITS;
      else if (is_slash && slot_eff < 2'd2) mode_pre = M_NUM_START;
      else if (is_blank || is_cr) mode_pre = M_GAP;
      else if (is_lf) mode_pre = M_START;
    end

    fin = (num_byte && (is_blank || is_cr || is_lf)) ||
          (eot_i && (mode_pre == M_NUM_START || mode_pre == M_NUM_DIGITS));
    mode_d = eot_i ? M_START : mode_pre;
  end

  // Number accumulation, corner storage and fan output.
  always_comb begin
    acc_d    = start_corner ? '0 : acc_q;
    neg_d    = start_corner ? 1'b0 : neg_q;
    slot_d   = slot_eff;
    cnt_d    = face_start ? 2'd0 : cnt_q;
    off_d    = off_q;
    first_d  = first_q;
    prev_d   = prev_q;
    tri_emit = 1'b0;
    tri_out  = '0;
    prod     = '0;
    for (int i = 0; i < 3; i++) cur_d[i] = start_corner ? '1 : cur_q[i];

    if (num_byte) begin
      if (is_digit) begin
        prod  = ({4'b0, acc_d} << 3) + ({4'b0, acc_d} << 1) +
                (ACC_W+4)'(byte_i - CH_0);
        acc_d = (prod[ACC_W+3:ACC_W] != 4'd0) ? '1 : prod[ACC_W-1:0];
      end else if (is_minus && num_mode == M_NUM_START) begin
        neg_d = 1'b1;
      end else if (is_slash && slot_d < 2'd2) begin
        for (int i = 0; i < 3; i++)
          if (slot_d == 2'(i)) cur_d[i] = field_value(acc_d, neg_d);
        slot_d = slot_d + 2'd1;
        acc_d  = '0;
        neg_d  = 1'b0;
      end
    end

    if (fin) begin
      for (int i = 0; i < 3; i++)
        if (slot_d == 2'(i)) cur_d[i] = field_value(acc_d, neg_d);
      case (cnt_d)
        2'd0: begin
          first_d = '{nrm: cur_d[2], tex: cur_d[1], pos: cur_d[0]};
          cnt_d   = 2'd1;
        end
        2'd1: begin
          prev_d = '{nrm: cur_d[2], tex: cur_d[1], pos: cur_d[0]};
          cnt_d  = 2'd2;
        end
        default: begin
          tri_emit = 1'b1;
          tri_out  = '{c: '{nrm: cur_d[2], tex: cur_d[1], pos: cur_d[0]},
                       b: prev_d, a: first_d};
          prev_d   = '{nrm: cur_d[2], tex: cur_d[1], pos: cur_d[0]};
          off_d    = off_d + OFF_W'(3);
        end
      endcase
    end

    end_off = off_d;
    if (eot_i) begin
      acc_d  = '0;
      neg_d  = 1'b0;
      slot_d = 2'd0;
      cnt_d  = 2'd0;
      off_d  = '0;
    end
  end

  assign push_o             = accept_i && (tri_emit || obj_emit || eot_i);
  assign bundle_o.has_first = tri_emit || obj_emit;
  assign bundle_o.first_obj = obj_emit;
  assign bundle_o.has_end   = eot_i;
  assign bundle_o.tri_data  = tri_out;
  assign bundle_o.first_off = obj_emit ? off_q : '0;
  assign bundle_o.end_off   = end_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_START;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      slot_q <= 2'd0;
      cnt_q  <= 2'd0;
      off_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      off_q  <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < 3; i++) cur_q[i] <= cur_d[i];
      first_q <= first_d;
      prev_q  <= prev_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/offt_queue.sv
// Short FIFO of result bundles between front and back end.
// Register array with read and write pointers and an occupancy count.
// Depends on offt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module offt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  offt_pkg::bundle_t  data_i,
  input  logic               pop_i,
  output offt_pkg::bundle_t  head_o,
  output logic               full_o,
  output logic               empty_o
);
  import offt_pkg::*;

  bundle_t           entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/offt_back.sv
// Back end: unpacks queued bundles into single results on the output
// register, one result per cycle while the consumer is ready. Depends on offt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module offt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  offt_pkg::bundle_t                 head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  logic                              m_axis_tready_i,
  output logic                              m_axis_tvalid_o,
  output logic [offt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic [1:0]                        m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import offt_pkg::*;

  logic                  valid_q, valid_d;
  logic                  phase_q, phase_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  kind_e                 kind_q, kind_d;
  logic                  last_q, last_d;
  logic                  sel_first, is_last, load;

  assign sel_first = head_i.has_first && !phase_q;
  assign is_last   = !(sel_first && head_i.has_end);
  assign load      = !empty_i && (!valid_q || m_axis_tready_i);
  assign pop_o     = load && is_last;

  always_comb begin
    valid_d = load || (valid_q && !m_axis_tready_i);
    phase_d = load ? !is_last : phase_q;
    if (sel_first) begin
      kind_d = head_i.first_obj ? KIND_OBJ : KIND_TRI;
      data_d = OUT_DATA_W'({head_i.first_off, head_i.tri_data});
    end else begin
      kind_d = KIND_END;
      data_d = OUT_DATA_W'({head_i.end_off, tri_t'('0)});
    end
    last_d = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

// File: rtl/obj_face_fan_triangulator.sv
// Wavefront OBJ face fan triangulator, top level. Depends on offt_pkg,
// offt_front, offt_queue and offt_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes OBJ text one byte per cycle on the slave stream (tlast marks
// the last byte of a text) and returns results on the master stream. Face lines
// ("f" then blank) yield one triangle per corner after the second, built from
// the first, the previous and the current corner; each part is the decimal
// value minus one, saturated at the index range, and -1 where absent. Lines
// starting "o" or "g" then blank yield an object start carrying the running
// index offset (grows by three per triangle, wraps at 2^32). The last byte of a
// text closes any open corner and yields an end result with the total count,
// after which the parser is back in its reset state. Each byte is processed in
// the cycle it is accepted, so input runs at one byte per clock; the output
// register delivers one result per clock while the consumer is ready; a byte
// causing two results (a triangle or object start plus the end of text) yields both in turn.
// A four-entry bundle queue decouples the parser from the output side, so a
// stalled consumer stops input only once that queue is full. Results for one
// byte leave in order, with tlast on the last of them. Corner fields of a
// non-triangle result and the offset of a triangle read as zero.
module obj_face_fan_triangulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [offt_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,   // [7:0] text_byte
  input  logic                              s_axis_tlast_i,   // end_of_text
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [24:0] pos_a, [49:25] tex_a, [74:50] nrm_a, [99:75] pos_b, [124:100] tex_b,
  // [149:125] nrm_b, [174:150] pos_c, [199:175] tex_c, [224:200] nrm_c,
  // [256:225] index_offset, rest zero
  output logic [offt_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic [1:0]                        m_axis_tuser_o,   // [1:0] kind
  output logic                              m_axis_tlast_o    // final_res
);
  import offt_pkg::*;

  logic    accept;
  logic    push, pop;
  logic    q_full, q_empty;
  bundle_t push_data, head;

  // Take a byte whenever the queue has room for what it may cause.
  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  offt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .eot_i    (s_axis_tlast_i),
    .push_o   (push),
    .bundle_o (push_data)
  );

  offt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  offt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Never write a full queue or read an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("bundle queue underflow");

  // An end-of-text result always closes its byte's results.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_END) |-> m_axis_tlast_o)
    else $error("end result without tlast");

  // Triangles carry no offset.
  a_tri_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_TRI) |->
      (m_axis_tdata_o[TRI_W +: OFF_W] == '0))
    else $error("triangle with nonzero offset");

endmodule

`default_nettype wire
